@@ design/four_pole_pulse_shape_macros.svh @@
// ----------------------------------------------------------------------------
// four_pole_pulse_shape_macros
// assertion helpers shared by the pulse shaper rtl
// ----------------------------------------------------------------------------
`ifndef FOUR_POLE_PULSE_SHAPE_MACROS_SVH
`define FOUR_POLE_PULSE_SHAPE_MACROS_SVH

// condition and consequence checked in the same cycle
`define FPPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the condition
`define FPPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fpps_pkg.sv @@
// ----------------------------------------------------------------------------
// fpps_pkg
// constants, register codes and table functions of the pulse shaper
// ----------------------------------------------------------------------------
package fpps_pkg;

  typedef logic [7:0]  cfg_index_t;
  typedef logic [31:0] cfg_word_t;

  // register codes
  localparam cfg_index_t REG_INV_FAST_TAU = 8'd0;
  localparam cfg_index_t REG_INV_SLOW_TAU = 8'd1;
  localparam cfg_index_t REG_POLY_RATE    = 8'd2;
  localparam cfg_index_t REG_AMPL_SCALE   = 8'd3;

  localparam cfg_word_t INV_FAST_TAU_RST = 32'd85899346;
  localparam cfg_word_t INV_SLOW_TAU_RST = 32'd343597384;
  localparam cfg_word_t POLY_RATE_RST    = 32'd257698038;
  localparam cfg_word_t AMPL_SCALE_RST   = 32'd65536;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [38:0] ONE_Q24   = 39'h00_0100_0000;
  localparam logic [38:0] POLY_CAP  = 39'h40_0000_0000;
  localparam logic [47:0] AMP_MAX     = 48'd262143;
  localparam logic [47:0] AMP_NEG_MAX = 48'd262144;
  localparam logic [18:0] AMP_POS_CODE = 19'h3FFFF;
  localparam logic [18:0] AMP_NEG_CODE = 19'h40000;

  // widest fraction index served by the direct table
  localparam int HI_BITS_MAX = 8;

  // floor square root, elaboration only
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitw;
    rem  = v;
    res  = 64'd0;
    bitw = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitw) begin
        rem = rem - (res + bitw);
        res = (res >> 1) + bitw;
      end else begin
        res = res >> 1;
      end
      bitw = bitw >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-j) in q0.32, j at least one
  function automatic logic [31:0] frac_root(input int j);
    logic [63:0] r;
    r = root_floor(64'h8000_0000_0000_0000);
    for (int i = 2; i <= j; i++) begin
      r = root_floor(r << 32);
    end
    return r[31:0];
  endfunction

  // 2^-(k / 2^nbits) in q0.32, 2^32 for k zero, rounded after each factor
  function automatic logic [32:0] frac_rom(input int k, input int nbits);
    logic [63:0] p;
    p = 64'h1_0000_0000;
    for (int j = 1; j <= nbits; j++) begin
      if (((k >> (nbits - j)) & 1) != 0) begin
        p = (p * {32'd0, frac_root(j)} + 64'h8000_0000) >> 32;
      end
    end
    return p[32:0];
  endfunction

endpackage

@@ design/fpps_decay.sv @@
// ----------------------------------------------------------------------------
// fpps_decay
// pipelined exp(-t * inv) in q.24, formed as 2^-y with shift and root table
// ----------------------------------------------------------------------------
module fpps_decay #(
  parameter int EXP_FRAC_BITS = 10,
  parameter int EXP_CLAMP     = 32,
  localparam int HI_BITS = (EXP_FRAC_BITS > fpps_pkg::HI_BITS_MAX) ?
                           fpps_pkg::HI_BITS_MAX : EXP_FRAC_BITS,
  localparam int LO_BITS = EXP_FRAC_BITS - HI_BITS,
  localparam int NSTAGE  = 4 + LO_BITS
) (
  input  logic              clk,
  input  logic [NSTAGE-1:0] en,
  input  logic [30:0]       t,
  input  logic [31:0]       inv,
  output logic [24:0]       e_q24
);
  import fpps_pkg::*;

  localparam int XW  = $clog2(EXP_CLAMP) + 24;
  localparam int YIW = XW - 23;
  localparam int KLW = (LO_BITS > 0) ? LO_BITS : 1;
  localparam int LON = (LO_BITS > 0) ? LO_BITS : 1;
  localparam int HI_ENTRIES = 1 << HI_BITS;
  localparam logic [63:0] CLAMP_LIM = 64'(EXP_CLAMP) << 48;

  logic [32:0] hi_rom [HI_ENTRIES];
  logic [31:0] lo_root [LON];

  for (genvar h = 0; h < HI_ENTRIES; h++) begin : g_hi
    assign hi_rom[h] = frac_rom(h << LO_BITS, EXP_FRAC_BITS);
  end
  for (genvar r = 0; r < LON; r++) begin : g_lo
    assign lo_root[r] = frac_root(HI_BITS + 1 + r);
  end

  logic [62:0]           prod;
  logic [XW-1:0]         x1;
  logic                  clamp1;
  logic [XW+30:0]        yprod;
  logic [YIW-1:0]        yi2;
  logic [EXP_FRAC_BITS-1:0] k2;
  logic                  zero2;
  logic [7:0]            sh;
  logic [32:0]           p_c   [LO_BITS+1];
  logic                  zero_c[LO_BITS+1];
  logic [5:0]            sh_c  [LO_BITS+1];
  logic [KLW-1:0]        klo_c [LO_BITS+1];
  logic [32:0]           p_rnd [LON];
  logic [65:0]           p_wide[LON];

  assign prod  = 63'(t) * 63'(inv);
  assign yprod = (XW+31)'(x1) * (XW+31)'(LOG2E_Q30);
  assign sh    = 8'(yi2) + 8'd8;

  always_comb begin
    for (int i = 0; i < LON; i++) begin
      p_wide[i] = 66'd0;
      p_rnd[i]  = 33'd0;
    end
    for (int i = 0; i < LO_BITS; i++) begin
      p_wide[i] = 66'(p_c[i]) * 66'(lo_root[i]) + 66'h8000_0000;
      p_rnd[i]  = p_wide[i][64:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      clamp1 <= {1'b0, prod} >= CLAMP_LIM;
      x1     <= prod[24 +: XW];
    end
    if (en[1]) begin
      zero2 <= clamp1;
      yi2   <= yprod[54 +: YIW];
      k2    <= yprod[54-EXP_FRAC_BITS +: EXP_FRAC_BITS];
    end
    if (en[2]) begin
      p_c[0]    <= hi_rom[k2[EXP_FRAC_BITS-1 -: HI_BITS]];
      zero_c[0] <= zero2 | (sh[7:6] != 2'b00);
      sh_c[0]   <= sh[5:0];
      klo_c[0]  <= KLW'(k2);
    end
    // one rounded root factor per stage, finest weights last
    for (int i = 0; i < LO_BITS; i++) begin
      if (en[3+i]) begin
        p_c[i+1]    <= klo_c[i][LO_BITS-1-i] ? p_rnd[i] : p_c[i];
        zero_c[i+1] <= zero_c[i];
        sh_c[i+1]   <= sh_c[i];
        klo_c[i+1]  <= klo_c[i];
      end
    end
    if (en[3+LO_BITS]) begin
      e_q24 <= zero_c[LO_BITS] ? 25'd0 : 25'(p_c[LO_BITS] >> sh_c[LO_BITS]);
    end
  end

endmodule

@@ design/four_pole_pulse_shape.sv @@
// ----------------------------------------------------------------------------
// four_pole_pulse_shape
// four-pole shaper response for one time sample per clock unless the output stalls, q2.16 out
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata: sample_time
//  m_*       out  m_tvalid/m_tready   tdata: amplitude, tuser: saturated
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
//  one sample per clock sustained while m_tready holds; the latency grows with
//  EXP_FRAC_BITS above 8 and is set by the multiplier pipeline of the two
//  exponentials, the polynomial and the final scaling.
//  reset loads the register defaults, clears all stage valid bits, drops ready.
//  a stage holds while the one after it is full and not moving, so a stall
//  at the output fills the bubbles first; config writes taken out of reset.
// ----------------------------------------------------------------------------
`include "four_pole_pulse_shape_macros.svh"

module four_pole_pulse_shape #(
  parameter int EXP_FRAC_BITS = 10,
  parameter int EXP_CLAMP     = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [31:0] sample_time
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [18:0] amplitude, [23:19] zero
  output logic [0:0]           m_tuser,   // [0] saturated
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  fpps_pkg::cfg_index_t cfg_index,
  input  fpps_pkg::cfg_word_t  cfg_data
);
  import fpps_pkg::*;

  localparam int HI_BITS = (EXP_FRAC_BITS > HI_BITS_MAX) ? HI_BITS_MAX : EXP_FRAC_BITS;
  localparam int LO_BITS = EXP_FRAC_BITS - HI_BITS;
  localparam int SD  = 4 + LO_BITS;  // exponentials ready
  localparam int SM  = SD + 1;       // partial products of e_slow * poly
  localparam int SP  = SD + 2;       // e_slow * poly
  localparam int SG  = SD + 3;       // difference and sign
  localparam int SA  = SD + 4;       // scale partial products
  localparam int SO  = SD + 5;       // output register
  localparam int NST = SO + 1;

  cfg_word_t inv_fast_tau, inv_slow_tau, poly_rate, ampl_scale;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_fast_tau <= INV_FAST_TAU_RST;
      inv_slow_tau <= INV_SLOW_TAU_RST;
      poly_rate    <= POLY_RATE_RST;
      ampl_scale   <= AMPL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INV_FAST_TAU: inv_fast_tau <= cfg_data;
        REG_INV_SLOW_TAU: inv_slow_tau <= cfg_data;
        REG_POLY_RATE:    poly_rate    <= cfg_data;
        REG_AMPL_SCALE:   ampl_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NST-1:0] v, en;
  logic [SA:0]    pos_d;

  always_comb begin
    en[NST-1] = ~v[NST-1] | m_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = ~v[i] | en[i+1];
    end
  end

  assign s_tready = en[0] && !rst;
  assign m_tvalid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) pos_d[0] <= !s_tdata[31] && (s_tdata != 32'd0);
    for (int i = 1; i <= SA; i++) begin
      if (en[i]) pos_d[i] <= pos_d[i-1];
    end
  end

  logic [30:0] t0;
  always_ff @(posedge clk) begin
    if (en[0]) t0 <= s_tdata[30:0];
  end

  logic [24:0] e_fast, e_slow;

  fpps_decay #(.EXP_FRAC_BITS(EXP_FRAC_BITS), .EXP_CLAMP(EXP_CLAMP)) u_fast (
    .clk   (clk),
    .en    (en[SD:1]),
    .t     (t0),
    .inv   (inv_fast_tau),
    .e_q24 (e_fast)
  );

  fpps_decay #(.EXP_FRAC_BITS(EXP_FRAC_BITS), .EXP_CLAMP(EXP_CLAMP)) u_slow (
    .clk   (clk),
    .en    (en[SD:1]),
    .t     (t0),
    .inv   (inv_slow_tau),
    .e_q24 (e_slow)
  );

  // polynomial 1 + u + u^2/2 alongside the exponentials
  logic [62:0] u_prod;
  logic [38:0] u1;
  logic        cap2;
  logic [30:0] u2;
  logic [61:0] usq;
  logic [36:0] usq2;
  logic [38:0] poly3;
  logic [38:0] poly_c [LO_BITS+1];

  assign u_prod = 63'(t0) * 63'(poly_rate);
  assign usq    = 62'(u1[30:0]) * 62'(u1[30:0]);

  always_ff @(posedge clk) begin
    if (en[1]) u1 <= u_prod[62:24];
    if (en[2]) begin
      cap2 <= u1[38:31] != 8'd0;
      u2   <= u1[30:0];
      usq2 <= usq[61:25];
    end
    if (en[3]) poly3 <= cap2 ? POLY_CAP : ONE_Q24 + 39'(u2) + 39'(usq2);
    if (en[4]) poly_c[0] <= poly3;
    for (int i = 1; i <= LO_BITS; i++) begin
      if (en[4+i]) poly_c[i] <= poly_c[i-1];
    end
  end

  // e_fast - e_slow * poly, then scale
  logic [44:0] plo_m;
  logic [43:0] phi_m;
  logic [24:0] e1_m, e1_p;
  logic [63:0] e2p_sum;
  logic [38:0] e2p_p;
  logic        neg_g, neg_a;
  logic [38:0] mag_g;
  logic [54:0] a_r, b_r;

  assign e2p_sum = {phi_m, 20'd0} + 64'(plo_m);

  always_ff @(posedge clk) begin
    if (en[SM]) begin
      plo_m <= 45'(e_slow) * 45'(poly_c[LO_BITS][19:0]);
      phi_m <= 44'(e_slow) * 44'(poly_c[LO_BITS][38:20]);
      e1_m  <= e_fast;
    end
    if (en[SP]) begin
      e2p_p <= e2p_sum[62:24];
      e1_p  <= e1_m;
    end
    if (en[SG]) begin
      neg_g <= e2p_p > 39'(e1_p);
      mag_g <= (e2p_p > 39'(e1_p)) ? e2p_p - 39'(e1_p) : 39'(e1_p) - e2p_p;
    end
    if (en[SA]) begin
      a_r   <= 55'(mag_g) * 55'(ampl_scale[31:16]);
      b_r   <= 55'(mag_g) * 55'(ampl_scale[15:0]);
      neg_a <= neg_g;
    end
  end

  logic [56:0] rnd;
  logic [47:0] sum;
  logic        sat_next;
  logic [18:0] clip, amp_next;
  logic [18:0] amp;
  logic        sat;

  always_comb begin
    // high product folded in before the single shift by 24
    rnd  = 57'(a_r[54:8]) + 57'({a_r[7:0], 16'd0}) + 57'(b_r) + 57'h80_0000;
    sum  = 48'(rnd[56:24]);
    sat_next = neg_a ? (sum > AMP_NEG_MAX) : (sum > AMP_MAX);
    if (sat_next) begin
      clip = neg_a ? AMP_NEG_MAX[18:0] : AMP_MAX[18:0];
    end else begin
      clip = sum[18:0];
    end
    amp_next = neg_a ? 19'd0 - clip : clip;
    // time at or below zero
    if (!pos_d[SA]) begin
      amp_next = 19'd0;
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[SO]) begin
      amp <= amp_next;
      sat <= sat_next;
    end
  end

  assign m_tdata = {5'd0, amp};
  assign m_tuser = sat;

  `FPPS_ASSERT_NOW(a_sat_at_limit, clk, rst, m_tvalid && m_tuser[0], (m_tdata[18:0] == AMP_POS_CODE) || (m_tdata[18:0] == AMP_NEG_CODE), "saturated result not at a range limit")
  `FPPS_ASSERT_NOW(a_stall_full, clk, rst, !s_tready, (&v) && !m_tready, "input stalled with a free stage")
  `FPPS_ASSERT_NEXT(a_nonpos_zero, clk, rst, v[SA] && en[SO] && !pos_d[SA], (m_tdata == 24'd0) && !m_tuser[0], "non-positive time gave a nonzero result")

endmodule

@@ tb/four_pole_pulse_shape_tb.sv @@
// ----------------------------------------------------------------------------
// four_pole_pulse_shape_tb
// self-checking bench for the four-pole pulse shaper
// ----------------------------------------------------------------------------
// Time samples are streamed into the shaper while the output side stalls at
// random. Every accepted sample is run through a bit-exact fixed-point model
// of the shaper, and the result is queued and compared against what comes
// out, amplitude and saturation flag separately. The run steps through the
// reset settings, a set of hand-picked extreme register settings and a series
// of random ones, rewriting the registers only once the pipeline is empty.
// ----------------------------------------------------------------------------
module four_pole_pulse_shape_tb;
  import fpps_pkg::*;

  localparam int EXP_FRAC_BITS = 10;
  localparam int EXP_CLAMP     = 32;
  localparam int PIPE_LAT      = 12;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 142;
  localparam int PRINT_CAP     = 200;

  localparam cfg_index_t REG_UNMAPPED_LO = 8'd4;
  localparam cfg_index_t REG_UNMAPPED_HI = 8'hFF;

  typedef struct packed {
    logic [18:0] amp;
    logic        sat;
  } shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'd0;    // [31:0] sample_time
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [18:0] amplitude, [23:19] zero
  logic [0:0]  m_tuser;            // [0] saturated
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = '0;
  cfg_word_t   cfg_data = '0;

  // shadow copy of the register file
  cfg_word_t fast_rate = INV_FAST_TAU_RST;
  cfg_word_t slow_rate = INV_SLOW_TAU_RST;
  cfg_word_t poly_coef = POLY_RATE_RST;
  cfg_word_t out_scale = AMPL_SCALE_RST;

  logic [63:0] root_q32 [1:EXP_FRAC_BITS];
  logic [63:0] pow2_frac [0:(1 << EXP_FRAC_BITS) - 1];

  logic [31:0] pending [$];
  shape_t      shape_q [$];
  shape_t      want;
  int          src_wait = 0;
  int          sink_wait = 0;
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int          fails = 0;
  int          cycle_count = 0;

  four_pole_pulse_shape #(
    .EXP_FRAC_BITS(EXP_FRAC_BITS),
    .EXP_CLAMP    (EXP_CLAMP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("four_pole_pulse_shape verification failed");
      $finish;
    end
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_len(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // exp(-t * rate) in q.24 through 2^-y, shift plus fraction table
  function automatic logic [63:0] decay_q24(input logic [63:0] t, input logic [63:0] rate);
    logic [63:0] prod;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] sh;
    int          k;
    prod = t * rate;
    if (prod >= (64'(EXP_CLAMP) << 48)) return 64'd0;
    x  = prod >> 24;
    y  = (x * 64'(LOG2E_Q30)) >> 24;
    k  = int'((y >> (30 - EXP_FRAC_BITS)) & ((64'd1 << EXP_FRAC_BITS) - 64'd1));
    sh = (y >> 30) + 64'd8;
    if (sh >= 64) return 64'd0;
    return pow2_frac[k] >> sh;
  endfunction

  function automatic shape_t shape_sample(input logic [31:0] raw);
    logic [63:0] t;
    logic [63:0] e_fast;
    logic [63:0] e_slow;
    logic [63:0] u;
    logic [63:0] poly;
    logic [63:0] slow_poly;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] sum;
    logic        neg;
    shape_t      res;
    res.amp = '0;
    res.sat = 1'b0;
    if (raw != 32'd0 && !raw[31]) begin
      t = 64'(raw);
      e_fast = decay_q24(t, 64'(fast_rate));
      e_slow = decay_q24(t, 64'(slow_rate));
      slow_poly = 64'd0;
      if (e_slow != 64'd0) begin
        u = (t * 64'(poly_coef)) >> 24;
        if (u >= (64'd1 << 31))
          poly = 64'(POLY_CAP);
        else
          poly = 64'(ONE_Q24) + u + ((u * u) >> 25);
        slow_poly = (e_slow * poly) >> 24;
      end
      neg = slow_poly > e_fast;
      mag = neg ? slow_poly - e_fast : e_fast - slow_poly;
      a = mag * 64'(out_scale[31:16]);
      b = mag * 64'(out_scale[15:0]);
      // the shaper folds the high partial product in this exact order
      sum = ((a >> 8) + ((a & 64'hFF) << 16) + b + (64'd1 << 23)) >> 24;
      if (!neg) begin
        if (sum > 64'(AMP_MAX)) begin
          sum = 64'(AMP_MAX);
          res.sat = 1'b1;
        end
        res.amp = sum[18:0];
      end else begin
        if (sum > 64'(AMP_NEG_MAX)) begin
          sum = 64'(AMP_NEG_MAX);
          res.sat = 1'b1;
        end
        res.amp = 19'(64'd0 - sum);
      end
    end
    return res;
  endfunction

  // sample source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) shape_q.push_back(shape_sample(s_tdata));
      if (src_wait != 0) begin
        s_tvalid <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (pending.size() != 0) begin
        s_tdata  <= pending.pop_front();
        s_tvalid <= 1'b1;
        src_wait <= idle_len(src_idle);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (shape_q.size() == 0) begin
          if (fails < PRINT_CAP)
            $display("%0t: unexpected result tdata %h tuser %b", $time, m_tdata, m_tuser);
          fails = fails + 1;
        end else begin
          want = shape_q.pop_front();
          if (m_tdata !== {5'd0, want.amp}) begin
            if (fails < PRINT_CAP)
              $display("%0t: amplitude expected %h actual %h", $time, want.amp, m_tdata);
            fails = fails + 1;
          end
          if (m_tuser[0] !== want.sat) begin
            if (fails < PRINT_CAP)
              $display("%0t: saturated expected %b actual %b", $time, want.sat, m_tuser[0]);
            fails = fails + 1;
          end
        end
      end
      if (sink_wait != 0) begin
        m_tready  <= 1'b0;
        sink_wait <= sink_wait - 1;
      end else begin
        m_tready  <= 1'b1;
        sink_wait <= idle_len(sink_idle);
      end
    end
  end

  task automatic write_reg(input cfg_index_t idx, input cfg_word_t val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INV_FAST_TAU: fast_rate = val;
      REG_INV_SLOW_TAU: slow_rate = val;
      REG_POLY_RATE:    poly_coef = val;
      REG_AMPL_SCALE:   out_scale = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input cfg_word_t f, input cfg_word_t s, input cfg_word_t p,
                           input cfg_word_t g);
    write_reg(REG_INV_FAST_TAU, f);
    write_reg(REG_INV_SLOW_TAU, s);
    write_reg(REG_POLY_RATE, p);
    write_reg(REG_AMPL_SCALE, g);
  endtask

  // wait out every queued sample and result, then let the pipeline settle
  task automatic drain_results();
    while (pending.size() != 0 || s_tvalid || shape_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  initial begin
    logic [63:0] seed;
    logic [63:0] rt;
    logic [63:0] trial;
    logic [63:0] p;
    logic [31:0] tv;
    int          j;
    int          k;
    int          bt;
    int          n;
    int          r;
    int          tp_f;
    int          tp_s;

    // chain of floor square roots: 2^-(2^-j) in q0.32
    seed = 64'h8000_0000_0000_0000;
    for (j = 1; j <= EXP_FRAC_BITS; j++) begin
      rt = 64'd0;
      for (bt = 31; bt >= 0; bt--) begin
        trial = rt | (64'd1 << bt);
        if (trial * trial <= seed) rt = trial;
      end
      root_q32[j] = rt;
      seed = rt << 32;
    end
    for (k = 0; k < (1 << EXP_FRAC_BITS); k++) begin
      p = 64'd1 << 32;
      for (j = 1; j <= EXP_FRAC_BITS; j++) begin
        if (((k >> (EXP_FRAC_BITS - j)) & 1) != 0)
          p = (p * root_q32[j] + (64'd1 << 31)) >> 32;
      end
      pow2_frac[k] = p;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: non-positive times, clamp of both exponentials
    @(negedge clk);
    pending = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0001_0000, 32'h0005_0000, 32'h000A_0000,
                32'h0019_0000, 32'h003C_0000, 32'h00C8_0000, 32'h03E8_0000};
    drain_results();

    // writes to unmapped indexes leave the registers alone
    write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED_HI, 32'h0000_0000);
    @(negedge clk);
    pending = '{32'h000A_0000, 32'h0019_0000};
    drain_results();

    // capped polynomial, negative saturation
    write_all(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    @(negedge clk);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    pending = '{32'h0000_0001, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0080_0000,
                32'hFFFF_0000};
    drain_results();

    // slow term clamped away, zero scale then full scale
    write_all(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    @(negedge clk);
    pending = '{32'h0001_0000, 32'h7FFF_FFFF};
    drain_results();
    write_reg(REG_AMPL_SCALE, 32'hFFFF_FFFF);
    @(negedge clk);
    pending = '{32'h0001_0000, 32'h7FFF_FFFF};
    drain_results();

    for (n = 0; n < RANDOM_PHASES; n++) begin
      if ($urandom_range(0, 2) != 0) begin
        // physical shaper: tp2 no longer than tp, b = 1/tp2 - 1/tp
        tp_f = $urandom_range(3, 300);
        tp_s = $urandom_range(2, tp_f);
        fast_rate = 32'((64'd1 << 32) / 64'(tp_f));
        slow_rate = 32'((64'd1 << 32) / 64'(tp_s));
        write_all(fast_rate, slow_rate, slow_rate - fast_rate,
                  32'($urandom_range(1 << 12, 1 << 20)));
      end else begin
        write_all($urandom, $urandom, $urandom, $urandom);
      end
      @(negedge clk);
      src_idle  = (n == 0) || ($urandom_range(0, 3) != 0);
      sink_idle = (n == 0) || ($urandom_range(0, 3) != 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 60)
          tv = $urandom_range(1, 200 << 16);
        else if (r < 72)
          tv = $urandom_range(200 << 16, 3000 << 16);
        else if (r < 80)
          tv = $urandom_range(0, 16);
        else if (r < 92)
          tv = $urandom;
        else
          tv = {1'b1, 31'($urandom)};
        pending.push_back(tv);
      end
      drain_results();
    end

    if (fails == 0) begin
      $display("four_pole_pulse_shape verification clean");
    end else begin
      $display("four_pole_pulse_shape verification failed");
    end
    $finish;
  end

endmodule
